// ----- design/bpra_pkg.sv -----
// Shared types, codes and bit-search helpers for the bitmap page run allocator.
// Depends on nothing; bpra_scan and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bpra_pkg;

  // Fixed field widths.
  localparam int PAGE_W   = 52;
  localparam int COUNT_W  = 13;
  localparam int SWORDS_W = 7;
  localparam int WORD_W   = 64;

  // Request codes.
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_MARK  = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;

  // Configuration register indexes.
  localparam logic [0:0] CFG_BASE_PAGE    = 1'b0;
  localparam logic [0:0] CFG_SEARCH_WORDS = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic [PAGE_W-1:0]  start_page;
    logic [COUNT_W-1:0] page_count;
  } bpra_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] result_page;
  } bpra_out_t;

  // Per-word summary produced by the scan datapath.
  typedef struct packed {
    logic [WORD_W-1:0] run_end;   // bit b set: an in-word free run of the count ends at b
    logic [6:0]        low_free;  // free pages from bit 0 upward (64 when all free)
    logic [6:0]        high_free; // free pages from bit 63 downward
  } bpra_scan_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REL,
    S_CHECK,
    S_AINIT,
    S_SCAN,
    S_LAST,
    S_MASK,
    S_WRITE,
    S_DONE
  } bpra_state_t;

  // Number of zero bits below the lowest one bit (64 when the word is zero).
  function automatic logic [6:0] ctz64(input logic [WORD_W-1:0] x);
    logic [6:0] r;
    r = 7'd64;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (x[i]) r = 7'(i);
    end
    return r;
  endfunction

  // Number of zero bits above the highest one bit (64 when the word is zero).
  function automatic logic [6:0] clz64(input logic [WORD_W-1:0] x);
    logic [6:0] r;
    r = 7'd64;
    for (int i = 0; i < WORD_W; i++) begin
      if (x[i]) r = 7'(WORD_W - 1 - i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/bpra_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bpra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/bpra_scan.sv -----
// Two-stage datapath that summarizes one bitmap word for the first-fit search.
// Depends on bpra_pkg for the summary struct and the bit-search helpers.
`timescale 1ns / 1ps
`default_nettype none

module bpra_scan (
  input  logic                     clk,
  input  logic [63:0]              rdata,
  input  logic [2:0]               sel_k,
  input  logic [5:0]               shift_d,
  input  logic                     too_long,
  output bpra_pkg::bpra_scan_t     res
);

  logic [63:0] e_nxt [7];
  logic [63:0] e_r [7];
  logic [6:0]  low_r;
  logic [6:0]  high_r;
  logic [63:0] sel;
  bpra_pkg::bpra_scan_t res_nxt;
  bpra_pkg::bpra_scan_t res_r;

  // Stage one: bit j of level k is set when 2^k free pages end at bit j.
  always_comb begin
    e_nxt[0] = ~rdata;
    for (int j = 1; j < 7; j++) begin
      e_nxt[j] = e_nxt[j-1] & (e_nxt[j-1] << (1 << (j - 1)));
    end
  end

  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    low_r  <= bpra_pkg::ctz64(rdata);
    high_r <= bpra_pkg::clz64(rdata);
  end

  // Stage two: a run of count c ends at bit b when two overlapping windows of
  // 2^k pages, k = floor(log2 c), end at b and at b - (c - 2^k).
  always_comb begin
    sel                = e_r[sel_k];
    res_nxt.run_end    = too_long ? '0 : (sel & (sel << shift_d));
    res_nxt.low_free   = low_r;
    res_nxt.high_free  = high_r;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- design/bitmap_page_run_allocator.sv -----
// First-fit page run allocator over a used/free bitmap held in one RAM of
// BITMAP_WORDS 64-bit words (one bit per page, one means used). After reset a
// clearing pass writes every word to zero, and no request is taken until it
// ends. Requests are handled one at a time. Allocate reads one bitmap word per
// cycle through the RAM read port and summarizes it through the RAM read
// register and the bpra_scan stage registers, stopping early when a run fits;
// the found run is then written back one word per cycle. Free and mark check
// the range and write back each word the run touches in the same way. Every
// request gives exactly one result word, which is held in an output register
// while the next request may already be accepted.
// Depends on bpra_pkg, bpra_ram and bpra_scan.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_run_allocator #(
  parameter int BITMAP_WORDS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bpra_pkg::bpra_in_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bpra_pkg::bpra_out_t    out_data,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [51:0]            cfg_data
);

  localparam int WAW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int PW  = WAW + 6;
  localparam int LW  = $clog2(BITMAP_WORDS + 1);
  localparam logic [52:0]    TOTAL_PAGES = 53'(BITMAP_WORDS * 64);
  localparam logic [WAW-1:0] LAST_WORD   = WAW'(BITMAP_WORDS - 1);
  localparam logic [LW-1:0]  WORDS_L     = LW'(BITMAP_WORDS);

  bpra_pkg::bpra_state_t state_r, state_nxt;

  // Configuration registers.
  logic [51:0] base_r;
  logic [6:0]  swords_r;

  // Request and working registers.
  bpra_pkg::bpra_in_t  req_r, req_nxt;
  logic [51:0]         rel_r, rel_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [51:0]         result_r, result_nxt;
  logic [PW-1:0]       first_r, first_nxt;
  logic [PW-1:0]       last_r, last_nxt;
  logic [63:0]         mlo_r, mlo_nxt;
  logic [63:0]         mhi_r, mhi_nxt;
  logic [LW-1:0]       limit_r, limit_nxt;
  logic [2:0]          k_r, k_nxt;
  logic [5:0]          d_r, d_nxt;
  logic                big_r, big_nxt;

  // Scan pipeline.
  logic [WAW-1:0] iss_r, iss_nxt;
  logic           iss_on_r, iss_on_nxt;
  logic           p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic [WAW-1:0] w1_r, w1_nxt, w2_r, w2_nxt, w3_r, w3_nxt;
  logic [12:0]    run_len_r, run_len_nxt;
  logic [PW-1:0]  run_start_r, run_start_nxt;

  // Write-back and clearing.
  logic [WAW-1:0] rd_w_r, rd_w_nxt;
  logic           rd_on_r, rd_on_nxt;
  logic           wr_pend_r, wr_pend_nxt;
  logic [WAW-1:0] wa_r, wa_nxt;
  logic [WAW-1:0] clr_r, clr_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  bpra_pkg::bpra_out_t out_data_r, out_data_nxt;

  // RAM port.
  logic           ram_we;
  logic [WAW-1:0] ram_waddr;
  logic [63:0]    ram_wdata;
  logic [WAW-1:0] ram_raddr;
  logic [63:0]    ram_rdata;

  // Derived values.
  logic [6:0]     c7;
  logic [2:0]     k_c;
  logic [5:0]     d_c;
  logic           big_c;
  logic [LW-1:0]  limit_c;
  logic           range_bad;
  logic [WAW-1:0] first_w, last_w;
  logic [63:0]    wmask;
  logic [63:0]    wword;
  logic           iss_last, w3_last;

  bpra_pkg::bpra_scan_t scan_res;
  logic [5:0]     hit_bit;
  logic           hit_in_word;
  logic [12:0]    need;
  logic           carry_hit;
  logic           found;
  logic           scan_end;
  logic [PW-1:0]  found_start;

  bpra_ram #(
    .WIDTH (64),
    .DEPTH (BITMAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpra_scan u_scan (
    .clk      (clk),
    .rdata    (ram_rdata),
    .sel_k    (k_r),
    .shift_d  (d_r),
    .too_long (big_r),
    .res      (scan_res)
  );

  // Split the count into its top power of two and the remainder.
  always_comb begin
    c7  = req_r.page_count[6:0];
    k_c = '0;
    for (int i = 0; i < 7; i++) begin
      if (c7[i]) k_c = 3'(i);
    end
    d_c   = 6'(c7 - (7'd1 << k_c));
    big_c = (req_r.page_count > 13'd64);
  end

  // Search window and range check.
  assign limit_c   = (int'(swords_r) >= BITMAP_WORDS) ? WORDS_L : LW'(swords_r);
  assign range_bad = ({1'b0, rel_r} + 53'(req_r.page_count)) > TOTAL_PAGES;
  assign first_w   = first_r[PW-1:6];
  assign last_w    = last_r[PW-1:6];
  assign iss_last  = (LW'(iss_r) + LW'(1)) == limit_r;
  assign w3_last   = (LW'(w3_r) + LW'(1)) == limit_r;

  // Combine one word summary with the run carried in from earlier words.
  always_comb begin
    hit_bit     = 6'(bpra_pkg::ctz64(scan_res.run_end));
    hit_in_word = |scan_res.run_end;
    need        = req_r.page_count - run_len_r;
    carry_hit   = (run_len_r != 13'd0) && (need <= 13'(scan_res.low_free));
    found       = p3_r && (carry_hit || hit_in_word);
    scan_end    = p3_r && (carry_hit || hit_in_word || w3_last);
    found_start = carry_hit ? run_start_r
                            : ({w3_r, hit_bit} - PW'(req_r.page_count - 13'd1));
  end

  // Bits of the current write-back word that the run covers.
  always_comb begin
    wmask = ((wa_r == first_w) ? mlo_r : {64{1'b1}})
          & ((wa_r == last_w)  ? mhi_r : {64{1'b1}});
    wword = (req_r.action == bpra_pkg::ACT_FREE) ? (ram_rdata & ~wmask)
                                                 : (ram_rdata | wmask);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpra_pkg::S_CLEAR: begin
        if (clr_r == LAST_WORD) state_nxt = bpra_pkg::S_IDLE;
      end
      bpra_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.action) inside
            bpra_pkg::ACT_ALLOC:                    state_nxt = bpra_pkg::S_AINIT;
            bpra_pkg::ACT_FREE, bpra_pkg::ACT_MARK: state_nxt = bpra_pkg::S_REL;
            default:                                state_nxt = bpra_pkg::S_DONE;
          endcase
        end
      end
      bpra_pkg::S_REL: state_nxt = bpra_pkg::S_CHECK;
      bpra_pkg::S_CHECK: begin
        if (range_bad || req_r.page_count == 13'd0) state_nxt = bpra_pkg::S_DONE;
        else                                        state_nxt = bpra_pkg::S_LAST;
      end
      bpra_pkg::S_AINIT: begin
        if (req_r.page_count == 13'd0 || limit_c == '0) state_nxt = bpra_pkg::S_DONE;
        else                                            state_nxt = bpra_pkg::S_SCAN;
      end
      bpra_pkg::S_SCAN: begin
        if (found)         state_nxt = bpra_pkg::S_LAST;
        else if (scan_end) state_nxt = bpra_pkg::S_DONE;
      end
      bpra_pkg::S_LAST: state_nxt = bpra_pkg::S_MASK;
      bpra_pkg::S_MASK: state_nxt = bpra_pkg::S_WRITE;
      bpra_pkg::S_WRITE: begin
        if (wr_pend_r && wa_r == last_w) state_nxt = bpra_pkg::S_DONE;
      end
      bpra_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = bpra_pkg::S_IDLE;
      end
      default: state_nxt = bpra_pkg::S_IDLE;
    endcase
  end

  // RAM controls by state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wa_r;
    ram_wdata = wword;
    ram_raddr = rd_w_r;
    unique case (state_r)
      bpra_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      bpra_pkg::S_SCAN:  ram_raddr = iss_r;
      bpra_pkg::S_WRITE: ram_we    = wr_pend_r;
      default: ;
    endcase
  end

  assign in_ready = (state_r == bpra_pkg::S_IDLE);

  // Datapath next values.
  always_comb begin
    req_nxt       = req_r;
    rel_nxt       = rel_r;
    status_nxt    = status_r;
    result_nxt    = result_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    mlo_nxt       = mlo_r;
    mhi_nxt       = mhi_r;
    limit_nxt     = limit_r;
    k_nxt         = k_r;
    d_nxt         = d_r;
    big_nxt       = big_r;
    iss_nxt       = iss_r;
    iss_on_nxt    = iss_on_r;
    p1_nxt        = 1'b0;
    p2_nxt        = 1'b0;
    p3_nxt        = 1'b0;
    w1_nxt        = iss_r;
    w2_nxt        = w1_r;
    w3_nxt        = w2_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    rd_w_nxt      = rd_w_r;
    rd_on_nxt     = rd_on_r;
    wr_pend_nxt   = 1'b0;
    wa_nxt        = rd_w_r;
    clr_nxt       = clr_r + WAW'(1);
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      bpra_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          status_nxt = bpra_pkg::STAT_DONE;
          result_nxt = '0;
        end
      end
      bpra_pkg::S_REL: begin
        rel_nxt = req_r.start_page - base_r;
      end
      bpra_pkg::S_CHECK: begin
        first_nxt = rel_r[PW-1:0];
        if (range_bad) status_nxt = bpra_pkg::STAT_RANGE;
      end
      bpra_pkg::S_AINIT: begin
        limit_nxt   = limit_c;
        k_nxt       = k_c;
        d_nxt       = d_c;
        big_nxt     = big_c;
        iss_nxt     = '0;
        iss_on_nxt  = 1'b1;
        run_len_nxt = '0;
        if (req_r.page_count == 13'd0 || limit_c == '0) status_nxt = bpra_pkg::STAT_NO_SPACE;
      end
      bpra_pkg::S_SCAN: begin
        // Issue one word read per cycle until the window is covered.
        if (iss_on_r) begin
          p1_nxt  = !scan_end;
          iss_nxt = iss_r + WAW'(1);
          if (iss_last) iss_on_nxt = 1'b0;
        end
        p2_nxt = p1_r && !scan_end;
        p3_nxt = p2_r && !scan_end;
        // Carry the free run across words when this word completes nothing.
        if (p3_r && !carry_hit && !hit_in_word) begin
          if (scan_res.low_free == 7'd64) begin
            if (run_len_r == 13'd0) run_start_nxt = {w3_r, 6'd0};
            run_len_nxt = run_len_r + 13'd64;
          end else begin
            run_len_nxt   = 13'(scan_res.high_free);
            run_start_nxt = {w3_r, 6'd0} + PW'(7'd64 - scan_res.high_free);
          end
        end
        if (found)         first_nxt  = found_start;
        else if (scan_end) status_nxt = bpra_pkg::STAT_NO_SPACE;
      end
      bpra_pkg::S_LAST: begin
        last_nxt = first_r + PW'(req_r.page_count - 13'd1);
      end
      bpra_pkg::S_MASK: begin
        mlo_nxt   = {64{1'b1}} << first_r[5:0];
        mhi_nxt   = {64{1'b1}} >> (6'd63 - last_r[5:0]);
        rd_w_nxt  = first_w;
        rd_on_nxt = 1'b1;
        if (req_r.action == bpra_pkg::ACT_ALLOC) result_nxt = base_r + 52'(first_r);
      end
      bpra_pkg::S_WRITE: begin
        // Read the next word while the previous one is written back.
        if (rd_on_r) begin
          wr_pend_nxt = 1'b1;
          wa_nxt      = rd_w_r;
          rd_w_nxt    = rd_w_r + WAW'(1);
          if (rd_w_r == last_w) rd_on_nxt = 1'b0;
        end
      end
      bpra_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.result_page = result_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpra_pkg::S_CLEAR;
      clr_r       <= '0;
      iss_on_r    <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      p3_r        <= 1'b0;
      rd_on_r     <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      swords_r    <= 7'd64;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_on_r    <= iss_on_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      p3_r        <= p3_nxt;
      rd_on_r     <= rd_on_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bpra_pkg::CFG_BASE_PAGE:    base_r   <= cfg_data;
          bpra_pkg::CFG_SEARCH_WORDS: swords_r <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    rel_r       <= rel_nxt;
    status_r    <= status_nxt;
    result_r    <= result_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    mlo_r       <= mlo_nxt;
    mhi_r       <= mhi_nxt;
    limit_r     <= limit_nxt;
    k_r         <= k_nxt;
    d_r         <= d_nxt;
    big_r       <= big_nxt;
    iss_r       <= iss_nxt;
    w1_r        <= w1_nxt;
    w2_r        <= w2_nxt;
    w3_r        <= w3_nxt;
    run_len_r   <= run_len_nxt;
    run_start_r <= run_start_nxt;
    rd_w_r      <= rd_w_nxt;
    wa_r        <= wa_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- test/bitmap_page_run_allocator_test.sv -----
// Self-checking testbench for the bitmap page run allocator: directed and random
// allocate, free and mark requests under changing base page and search window.
// Depends on bpra_pkg and the bitmap_page_run_allocator top level.
`timescale 1ns / 1ps

module bitmap_page_run_allocator_test;
  import bpra_pkg::*;

  localparam int MAP_WORDS = 64;
  localparam int TOTAL_PAGES = MAP_WORDS * 64;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bpra_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bpra_out_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_BASE_PAGE;
  logic [51:0] cfg_data = '0;

  // Predicted block state.
  logic [TOTAL_PAGES-1:0] page_used_map = '0;
  logic [PAGE_W-1:0] base_page_reg = '0;
  logic [6:0] search_words_reg = 7'd64;

  bpra_in_t request_queue[$];
  bpra_out_t expected_replies[$];
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  logic steady = 1'b0;

  bitmap_page_run_allocator #(
    .BITMAP_WORDS(MAP_WORDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Sets or clears a run of pages in the predicted bitmap.
  function automatic void set_pages(int unsigned first, int unsigned count, logic used);
    for (int unsigned q = first; q < first + count; q++) page_used_map[q] = used;
  endfunction

  // Applies one request to the predicted bitmap and returns the reply it gives.
  function automatic bpra_out_t apply_request(bpra_in_t req);
    bpra_out_t rsp;
    int unsigned limit;
    int unsigned run_first;
    int unsigned run_len;
    logic found;
    logic [PAGE_W-1:0] rel;
    rsp = '0;
    found = 1'b0;
    run_first = 0;
    run_len = 0;
    case (req.action)
      ACT_ALLOC: begin
        limit = (search_words_reg > MAP_WORDS) ? TOTAL_PAGES : search_words_reg * 64;
        // First fit: any used page restarts the candidate run.
        if (req.page_count != 0) begin
          for (int unsigned p = 0; p < limit && !found; p++) begin
            if (page_used_map[p]) begin
              run_len = 0;
            end else begin
              if (run_len == 0) run_first = p;
              run_len++;
              if (run_len == req.page_count) found = 1'b1;
            end
          end
        end
        if (found) begin
          set_pages(run_first, req.page_count, 1'b1);
          rsp.result_page = PAGE_W'(run_first) + base_page_reg;
        end else begin
          rsp.status = STAT_NO_SPACE;
        end
      end
      ACT_FREE, ACT_MARK: begin
        rel = req.start_page - base_page_reg;
        if (64'(rel) + 64'(req.page_count) > 64'(TOTAL_PAGES)) rsp.status = STAT_RANGE;
        else set_pages(int'(rel), req.page_count, req.action == ACT_MARK);
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Run length, mostly short with an occasional long one.
  function automatic logic [COUNT_W-1:0] random_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return COUNT_W'($urandom_range(1, 16));
    if (pick < 90) return COUNT_W'($urandom_range(17, 256));
    if (pick < 98) return COUNT_W'($urandom_range(257, 1024));
    return COUNT_W'($urandom_range(1025, TOTAL_PAGES));
  endfunction

  // Mostly well-formed requests inside the bitmap, with some noise.
  function automatic bpra_in_t random_request();
    bpra_in_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.start_page = PAGE_W'({$urandom, $urandom});
    r.page_count = random_count();
    if (pick < 45) begin
      r.action = ACT_ALLOC;
    end else if (pick < 88) begin
      r.action = (pick < 75) ? ACT_FREE : ACT_MARK;
      r.start_page = base_page_reg + PAGE_W'($urandom_range(0, TOTAL_PAGES - 1));
      if ($urandom_range(0, 49) == 0) begin
        r.start_page = base_page_reg;
        r.page_count = COUNT_W'(TOTAL_PAGES);
      end
    end else if (pick < 92) begin
      // Arbitrary start, almost always outside the bitmap.
      r.action = $urandom_range(0, 1) ? ACT_FREE : ACT_MARK;
    end else if (pick < 95) begin
      r.action = 2'($urandom_range(0, 2));
      r.page_count = '0;
    end else if (pick < 97) begin
      r.action = ACT_UNUSED;
      r.page_count = COUNT_W'($urandom);
    end else begin
      r.action = 2'($urandom_range(0, 2));
      r.page_count = COUNT_W'($urandom);
    end
    return r;
  endfunction

  task automatic queue_request(logic [1:0] action, logic [PAGE_W-1:0] start,
                               logic [COUNT_W-1:0] count);
    bpra_in_t r;
    r.action = action;
    r.start_page = start;
    r.page_count = count;
    request_queue.push_back(r);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) request_queue.push_back(random_request());
  endtask

  // Waits until every queued word is sent and every reply has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] index, logic [51:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_BASE_PAGE) base_page_reg = value;
    else search_words_reg = value[6:0];
  endtask

  // Reconfigures only once the block has gone quiet.
  task automatic reconfigure(logic [PAGE_W-1:0] base, logic [6:0] words);
    wait_drained();
    repeat (10) @(posedge clk);
    write_reg(CFG_BASE_PAGE, base);
    write_reg(CFG_SEARCH_WORDS, 52'(words));
  endtask

  // Sender: presents the next queued word, idling at random.
  always @(posedge clk) begin
    logic next_valid;
    bpra_in_t next_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_data = in_data;
      if (in_valid && in_ready) begin
        expected_replies.push_back(apply_request(in_data));
        next_valid = 1'b0;
      end
      if (!next_valid && request_queue.size() != 0 &&
          (steady || $urandom_range(0, 99) >= 25)) begin
        next_data = request_queue.pop_front();
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
      in_data <= next_data;
    end
  end

  // Receiver: checks each reply word against the oldest prediction.
  always @(posedge clk) begin
    bpra_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply word with nothing expected: status %0d result_page %0h",
                 out_data.status, out_data.result_page);
          failures++;
        end else begin
          want = expected_replies.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            failures++;
          end
          if (out_data.result_page !== want.result_page) begin
            $error("result_page: expected %0h, actual %0h",
                   want.result_page, out_data.result_page);
            failures++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults after reset: base 0, whole bitmap searched.
    queue_request(ACT_ALLOC, '0, 13'd1);
    queue_request(ACT_ALLOC, '0, 13'd0);
    queue_request(ACT_MARK, 52'd64, 13'd64);
    queue_request(ACT_ALLOC, PAGE_MAX, 13'd100);   // run must skip the full word
    queue_request(ACT_FREE, 52'd4095, 13'd1);
    queue_request(ACT_FREE, 52'd4095, 13'd2);      // one page past the end
    queue_request(ACT_FREE, PAGE_MAX, 13'd1);
    queue_request(ACT_MARK, 52'h5_A5A5_A5A5_A5A5, 13'd0);
    queue_request(ACT_UNUSED, 52'h3_1234_5678_9ABC, 13'd77);
    queue_request(ACT_ALLOC, '0, 13'd4096);
    queue_request(ACT_FREE, '0, 13'd4096);
    queue_request(ACT_ALLOC, '0, 13'd4096);
    queue_request(ACT_ALLOC, '0, 13'd1);           // bitmap full
    queue_request(ACT_FREE, '0, 13'd4096);
    queue_request(ACT_ALLOC, '0, 13'h1FFF);        // larger than the bitmap
    queue_request(ACT_MARK, '0, 13'h1FFF);
    queue_request(ACT_MARK, '0, 13'd4096);
    queue_request(ACT_FREE, 52'd4000, 13'd96);
    queue_request(ACT_ALLOC, '0, 13'd96);
    queue_request(ACT_FREE, '0, 13'd4096);
    queue_request(ACT_ALLOC, 52'h0_0000_0000_0001, 13'd5);

    // Highest base page and a single searched word.
    reconfigure(PAGE_MAX, 7'd1);
    queue_request(ACT_ALLOC, '0, 13'd64);
    queue_request(ACT_ALLOC, '0, 13'd1);
    queue_request(ACT_FREE, PAGE_MAX, 13'd64);
    queue_request(ACT_ALLOC, '0, 13'd65);          // longer than the window
    queue_request(ACT_FREE, '0, 13'd10);
    queue_random(150);

    // Empty search window: every allocation fails.
    reconfigure(PAGE_W'({$urandom, $urandom}), 7'd0);
    queue_request(ACT_ALLOC, '0, 13'd1);
    queue_random(100);

    // Window register above the bitmap size.
    reconfigure(base_page_reg, 7'd127);
    queue_random(150);

    // Stretch with no idling on either side.
    reconfigure('0, 7'd64);
    steady = 1'b1;
    queue_random(300);
    wait_drained();
    steady = 1'b0;

    // Random settings; each phase pauses the sender halfway until all replies are in.
    repeat (6) begin
      reconfigure($urandom_range(0, 3) == 0 ? PAGE_MAX - PAGE_W'($urandom_range(0, 2000))
                                            : PAGE_W'({$urandom, $urandom}),
                  7'($urandom_range(1, MAP_WORDS)));
      queue_random(100);
      wait_drained();
      queue_random(100);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/bpra_pkg.sv
design/bpra_ram.sv
design/bpra_scan.sv
design/bitmap_page_run_allocator.sv
test/bitmap_page_run_allocator_test.sv
